// ===== hdl/kvat_pkg.sv =====
package kvat_pkg;

    localparam int KIND_W  = 3;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TEST   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } kvat_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      found;
        logic                      table_full;
    } kvat_rsp_t;

endpackage

// ===== hdl/key_value_accumulate_table_core.sv =====
// Associative table of ENTRIES signed 32-bit values addressed by signed 32-bit
// keys. Each input word carries one operation in s_axis_tuser (add, set,
// remove, read, test, clear all; other codes are ignored) and each gives
// exactly one result word in order. All slots are compared in parallel and
// the table is updated in the same cycle the operation is executed, so the
// core takes one word per clock cycle sustained while m_axis_tready stays high;
// each word passes through the input register, then the result register.
// New keys go to the lowest free slot; when none is free the word is dropped
// and flagged with table_full. Adds wrap modulo 2^32. The valid bits clear at
// reset, so words are accepted right after reset is released.
// Input tready follows m_axis_tready combinationally through the result stage.
module key_value_accumulate_table_core import kvat_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [1:0]  m_axis_tuser    // [0] found, [1] table_full
);

    logic      in_valid_reg;
    kvat_req_t in_req_reg;
    logic      out_valid_reg;
    kvat_rsp_t out_rsp_reg;
    kvat_rsp_t rsp;
    logic      advance;

    // Execute the held word whenever the result register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_req_reg.kind  <= s_axis_tuser;
            in_req_reg.key   <= s_axis_tdata[31:0];
            in_req_reg.value <= s_axis_tdata[63:32];
        end
    end

    kvat_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_rsp_reg.result_value;
    assign m_axis_tuser[0] = out_rsp_reg.found;
    assign m_axis_tuser[1] = out_rsp_reg.table_full;

endmodule

// ===== hdl/kvat_match.sv =====
// Parallel key compare over all slots plus lowest-free-slot pick.
// Keys are kept unique by the store, so hit_vec has at most one bit set.
module kvat_match import kvat_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic [ENTRIES-1:0]                valid,
    input  logic signed [KEY_W-1:0]           slot_key [ENTRIES],
    input  logic signed [KEY_W-1:0]           key,
    output logic [ENTRIES-1:0]                hit_vec,
    output logic [ENTRIES-1:0]                free_vec
);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = valid[i] && (slot_key[i] == key);
        end
    end

    // lowest clear bit of valid: ~v & (v + 1)
    assign free_vec = ~valid & (valid + {{(ENTRIES-1){1'b0}}, 1'b1});

endmodule

// ===== hdl/kvat_store.sv =====
// Slot registers and the combinational update logic for one operation.
module kvat_store import kvat_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  kvat_req_t req,
    output kvat_rsp_t rsp
);

    logic [ENTRIES-1:0]          valid_reg;
    logic [ENTRIES-1:0]          valid_next;
    logic signed [KEY_W-1:0]     key_reg   [ENTRIES];
    logic signed [VALUE_W-1:0]   value_reg [ENTRIES];

    logic [ENTRIES-1:0]          hit_vec;
    logic [ENTRIES-1:0]          free_vec;
    logic                        hit_any;
    logic                        free_any;
    logic signed [VALUE_W-1:0]   hit_value;
    logic signed [VALUE_W-1:0]   wr_value;
    logic [ENTRIES-1:0]          value_we;
    logic [ENTRIES-1:0]          key_we;

    kvat_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .valid    (valid_reg),
        .slot_key (key_reg),
        .key      (req.key),
        .hit_vec  (hit_vec),
        .free_vec (free_vec)
    );

    assign hit_any  = |hit_vec;
    assign free_any = |free_vec;

    // one-hot AND-OR read of the matching slot
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | (hit_vec[i] ? value_reg[i] : '0);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        value_we   = '0;
        key_we     = '0;
        wr_value   = req.value;
        rsp        = '0;
        unique case (req.kind) inside
            KIND_ADD, KIND_SET: begin
                if (hit_any) begin
                    if (req.kind == KIND_ADD) begin
                        wr_value = hit_value + req.value;
                    end
                    value_we         = hit_vec;
                    rsp.found        = 1'b1;
                    rsp.result_value = wr_value;
                end else if (free_any) begin
                    valid_next       = valid_reg | free_vec;
                    value_we         = free_vec;
                    key_we           = free_vec;
                    rsp.result_value = req.value;
                end else begin
                    rsp.table_full = 1'b1;
                end
            end
            KIND_REMOVE: begin
                valid_next = valid_reg & ~hit_vec;
                rsp.found  = hit_any;
            end
            KIND_READ: begin
                rsp.found        = hit_any;
                rsp.result_value = hit_value;
            end
            KIND_TEST: begin
                rsp.found = hit_any;
            end
            KIND_CLEAR: begin
                valid_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (en && key_we[i]) begin
                key_reg[i] <= req.key;
            end
            if (en && value_we[i]) begin
                value_reg[i] <= wr_value;
            end
        end
    end

endmodule

// ===== dv/key_value_accumulate_table_core_tb.sv =====
`timescale 1ns / 100ps

module key_value_accumulate_table_core_tb;
    import kvat_pkg::*;

    localparam int          SLOTS       = 16;
    localparam int          STALL_LIMIT = 1000;
    localparam int          HOLD_CYCLES = 80;
    localparam logic [31:0] INT_MIN     = 32'h8000_0000;
    localparam logic [31:0] INT_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
    // codes the block ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef enum {TX_STEADY, TX_BURSTY} tx_mode_t;
    typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_CADENCE} rx_mode_t;

    // Shadow copy of the key/value table plus the words it still owes.
    class kv_table_shadow;
        bit          live   [SLOTS];
        logic [31:0] key_of [SLOTS];
        logic [31:0] val_of [SLOTS];
        kvat_rsp_t   replies_due [$];
        int          mismatches;

        function void apply_op(kvat_req_t op);
            kvat_rsp_t r;
            int        hit;
            int        spare;
            r     = '0;
            hit   = -1;
            spare = -1;
            // walk downward so the lowest match / free slot wins
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (live[i] && key_of[i] == op.key)
                    hit = i;
                if (!live[i])
                    spare = i;
            end
            case (op.kind) inside
                KIND_ADD, KIND_SET: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        if (op.kind == KIND_ADD)
                            val_of[hit] = val_of[hit] + op.value;
                        else
                            val_of[hit] = op.value;
                        r.result_value = val_of[hit];
                    end else if (spare < 0) begin
                        r.table_full = 1'b1;
                    end else begin
                        live[spare]    = 1'b1;
                        key_of[spare]  = op.key;
                        val_of[spare]  = op.value;
                        r.result_value = op.value;
                    end
                end
                KIND_REMOVE: begin
                    if (hit >= 0) begin
                        r.found   = 1'b1;
                        live[hit] = 1'b0;
                    end
                end
                KIND_READ: begin
                    if (hit >= 0) begin
                        r.found        = 1'b1;
                        r.result_value = val_of[hit];
                    end
                end
                KIND_TEST: begin
                    if (hit >= 0)
                        r.found = 1'b1;
                end
                KIND_CLEAR: begin
                    for (int i = 0; i < SLOTS; i++)
                        live[i] = 1'b0;
                end
                default: ;
            endcase
            replies_due = {replies_due, r};
        endfunction

        function void check_reply(kvat_rsp_t got);
            kvat_rsp_t want;
            if (replies_due.size() == 0) begin
                $display("%0t: result word with none pending: value %h found %b full %b",
                         $time, got.result_value, got.found, got.table_full);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got.result_value !== want.result_value) begin
                $display("%0t: result_value expected %h actual %h",
                         $time, want.result_value, got.result_value);
                mismatches++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found expected %b actual %b", $time, want.found, got.found);
                mismatches++;
            end
            if (got.table_full !== want.table_full) begin
                $display("%0t: table_full expected %b actual %b",
                         $time, want.table_full, got.table_full);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [31:0] key, [63:32] value
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] result_value
    logic [1:0]  m_axis_tuser;         // [0] found, [1] table_full

    kv_table_shadow shadow;
    tx_mode_t       tx_mode    = TX_BURSTY;
    rx_mode_t       rx_mode    = RX_MOSTLY;
    int             burst_left = 0;
    bit             hold_req   = 1'b0;
    int             idle_cycles = 0;

    key_value_accumulate_table_core #(.ENTRIES(SLOTS)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Handshake monitor: result side first, its expectation is always older.
    always @(posedge aclk) begin : mon
        kvat_req_t op;
        kvat_rsp_t got;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.result_value = m_axis_tdata;
                got.found        = m_axis_tuser[0];
                got.table_full   = m_axis_tuser[1];
                shadow.check_reply(got);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op.kind  = s_axis_tuser;
                op.key   = s_axis_tdata[31:0];
                op.value = s_axis_tdata[63:32];
                shadow.apply_op(op);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("key_value_accumulate_table_core_tb: FAIL");
                $finish;
            end
        end
    end

    // Receiver backpressure; a long hold-off can be requested by the main flow.
    initial begin : rx_drive
        int hold_left;
        int beat;
        hold_left = 0;
        beat      = 0;
        forever begin
            @(negedge aclk);
            beat++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:  m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:    m_axis_tready <= ((beat % 5) < 3);
                endcase
            end
        end
    end

    task automatic send_word(input logic [2:0] kind, input logic [31:0] key,
                             input logic [31:0] value);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {value, key};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Sender: in TX_BURSTY mode, random-length bursts separated by random gaps; in TX_STEADY mode no gaps.
    task automatic offer(input logic [2:0] kind, input logic [31:0] key,
                         input logic [31:0] value);
        int gap;
        if (tx_mode == TX_BURSTY && burst_left == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        send_word(kind, key, value);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (shadow.replies_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_directed();
        logic [31:0] fill_key;
        logic [31:0] fill_val;
        offer(KIND_READ, 32'd5, 32'd0);                 // read on empty table
        for (int i = 0; i < SLOTS; i++) begin
            case (i)
                0:       fill_key = INT_MIN;
                1:       fill_key = INT_MAX;
                2:       fill_key = 32'd0;
                3:       fill_key = ALL_ONES;
                default: fill_key = i * 32'h0101_0101 + 32'd5;
            endcase
            fill_val = (i == 0) ? INT_MIN : (i == 1) ? INT_MAX : $urandom;
            offer((i % 2) ? KIND_SET : KIND_ADD, fill_key, fill_val);
        end
        offer(KIND_ADD, 32'h1234_5678, 32'd1);          // new key, table full
        offer(KIND_SET, 32'h1234_5678, 32'd1);
        offer(KIND_ADD, INT_MAX, 32'd1);                // wraps to min
        offer(KIND_ADD, INT_MIN, INT_MIN);              // wraps to zero
        offer(KIND_SET, 32'd0, INT_MAX);                // existing key while full
        offer(KIND_READ, ALL_ONES, 32'd0);
        offer(KIND_TEST, INT_MAX, ALL_ONES);
        offer(KIND_TEST, 32'h1234_5678, 32'd0);
        offer(KIND_REMOVE, 32'd0, 32'd0);
        offer(KIND_REMOVE, 32'd0, 32'd0);               // already gone
        offer(KIND_ADD, 32'h1234_5678, ALL_ONES);       // takes the freed slot
        offer(KIND_SPARE_LO, INT_MAX, INT_MAX);
        offer(KIND_SPARE_HI, 32'h1234_5678, ALL_ONES);
        offer(KIND_CLEAR, INT_MAX, 32'd0);
        offer(KIND_READ, INT_MAX, 32'd0);
    endtask

    // Keys come mostly from a small pool so hits, misses and a full table all occur.
    task automatic run_random(input int n_ops, input int pool_n);
        logic [31:0] pool [48];
        logic [31:0] key;
        logic [31:0] value;
        logic [2:0]  kind;
        int          pick;
        int          done;
        pool[0] = INT_MIN;
        pool[1] = INT_MAX;
        pool[2] = 32'd0;
        pool[3] = ALL_ONES;
        for (int i = 4; i < 48; i++)
            pool[i] = $urandom;
        done = 0;
        while (done < n_ops) begin
            key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
            case ($urandom_range(0, 9))
                0:       value = INT_MIN;
                1:       value = INT_MAX;
                2:       value = ALL_ONES;
                default: value = $urandom;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = KIND_ADD;
            else if (pick < 45) kind = KIND_SET;
            else if (pick < 63) kind = KIND_REMOVE;
            else if (pick < 78) kind = KIND_READ;
            else if (pick < 92) kind = KIND_TEST;
            else if (pick < 95) kind = KIND_CLEAR;
            else                kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
            offer(kind, key, value);
            if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
                done++;
        end
    endtask

    initial begin
        shadow = new;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_mode = TX_BURSTY;
        rx_mode = RX_MOSTLY;
        run_directed();
        wait_drained();

        tx_mode = TX_STEADY;
        rx_mode = RX_ALWAYS;
        run_random(200, 10);
        wait_drained();

        tx_mode = TX_BURSTY;
        rx_mode = RX_COIN;
        run_random(300, 24);
        wait_drained();

        // receiver goes quiet while the sender keeps pushing words
        tx_mode  = TX_STEADY;
        rx_mode  = RX_MOSTLY;
        hold_req = 1'b1;
        run_random(200, 40);
        wait_drained();

        tx_mode = TX_BURSTY;
        rx_mode = RX_CADENCE;
        run_random(300, 20);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
            $display("key_value_accumulate_table_core_tb: PASS");
        else
            $display("key_value_accumulate_table_core_tb: FAIL");
        $finish;
    end

endmodule
